### src/lfu_dir_pkg.sv
// Shared constants and control types for the LFU cache directory.
package lfu_dir_pkg;

    // Capacity register
    localparam int             CFG_W     = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    // Defaults for the top-level parameters
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_COUNT_BITS  = 16;

    // Control from the sequencer into the scan tracker
    typedef struct packed {
        logic clear;   // start of a new lookup
        logic en;      // read data for one entry is present
    } t_scan_ctl;

    // Status from the scan tracker
    typedef struct packed {
        logic found;        // key matched a valid entry
        logic have_victim;  // at least one valid entry seen
        logic have_free;    // at least one free entry seen
    } t_scan_flags;

endpackage

### src/lfu_dir_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module lfu_dir_ram
    import lfu_dir_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/lfu_dir_scan.sv
// Scan tracker: finds the hit entry, the LFU victim and the first free entry.
module lfu_dir_scan
    import lfu_dir_pkg::*;
#(
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int IDX_W      = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_scan_ctl             i_ctl,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic                  i_valid,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [IDX_W-1:0]      i_rank,
    input  logic [KEY_BITS-1:0]   i_lookup_key,
    output t_scan_flags           o_flags,
    output logic [IDX_W-1:0]      o_hit_idx,
    output logic [COUNT_BITS-1:0] o_hit_count,
    output logic [IDX_W-1:0]      o_hit_rank,
    output logic [IDX_W-1:0]      o_vic_idx,
    output logic [KEY_BITS-1:0]   o_vic_key,
    output logic [IDX_W-1:0]      o_vic_rank,
    output logic [IDX_W-1:0]      o_free_idx
);

    t_scan_flags           r_flags, n_flags;
    logic [IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_count, n_hit_count;
    logic [IDX_W-1:0]      r_hit_rank, n_hit_rank;
    logic [IDX_W-1:0]      r_vic_idx, n_vic_idx;
    logic [KEY_BITS-1:0]   r_vic_key, n_vic_key;
    logic [COUNT_BITS-1:0] r_vic_count, n_vic_count;
    logic [IDX_W-1:0]      r_vic_rank, n_vic_rank;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;

    logic w_is_hit;
    logic w_better;
    logic w_is_free;

    // first matching valid entry
    assign w_is_hit  = i_valid && (i_key == i_lookup_key) && !r_flags.found;
    // lower count wins, then older (higher rank)
    assign w_better  = i_valid && (!r_flags.have_victim || (i_count < r_vic_count) ||
                       ((i_count == r_vic_count) && (i_rank > r_vic_rank)));
    // lowest-index free entry
    assign w_is_free = !i_valid && !r_flags.have_free;

    always_comb begin
        n_flags     = r_flags;
        n_hit_idx   = r_hit_idx;
        n_hit_count = r_hit_count;
        n_hit_rank  = r_hit_rank;
        n_vic_idx   = r_vic_idx;
        n_vic_key   = r_vic_key;
        n_vic_count = r_vic_count;
        n_vic_rank  = r_vic_rank;
        n_free_idx  = r_free_idx;
        if (i_ctl.clear) begin
            n_flags = '0;
        end else if (i_ctl.en) begin
            if (w_is_hit) begin
                n_flags.found = 1'b1;
                n_hit_idx     = i_idx;
                n_hit_count   = i_count;
                n_hit_rank    = i_rank;
            end
            if (w_better) begin
                n_flags.have_victim = 1'b1;
                n_vic_idx           = i_idx;
                n_vic_key           = i_key;
                n_vic_count         = i_count;
                n_vic_rank          = i_rank;
            end
            if (w_is_free) begin
                n_flags.have_free = 1'b1;
                n_free_idx        = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
        r_hit_idx   <= n_hit_idx;
        r_hit_count <= n_hit_count;
        r_hit_rank  <= n_hit_rank;
        r_vic_idx   <= n_vic_idx;
        r_vic_key   <= n_vic_key;
        r_vic_count <= n_vic_count;
        r_vic_rank  <= n_vic_rank;
        r_free_idx  <= n_free_idx;
    end

    assign o_flags     = r_flags;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_count = r_hit_count;
    assign o_hit_rank  = r_hit_rank;
    assign o_vic_idx   = r_vic_idx;
    assign o_vic_key   = r_vic_key;
    assign o_vic_rank  = r_vic_rank;
    assign o_free_idx  = r_free_idx;

endmodule

### src/lfu_cache_directory_core.sv
// LFU cache directory: entry RAM, scan tracker and lookup/update sequencer.
// Each lookup runs one read pass over the entry RAM to match and pick the victim, a decide
//   state, one read-modify-write pass to age ranks and write the entry, and the output load.
// A new lookup is taken only back in idle, after the output load, as both passes share the
//   single RAM read port; a result held by the sink stalls the sequencer before the output load.
// Reset (synchronous, active low) clears valid bits, occupancy and handshakes; capacity goes to 16.
module lfu_cache_directory_core
    import lfu_dir_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS,
    localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // lookup channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [KEY_BITS-1:0]   i_lookup_key,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_hit,
    output logic [IDX_W-1:0]      o_slot,
    output logic [COUNT_BITS-1:0] o_new_count,
    output logic                  o_evicted,
    output logic [KEY_BITS-1:0]   o_evicted_key
);

    localparam int PTR_W = $clog2(MAX_ENTRIES + 1);
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam int MEM_W = KEY_BITS + COUNT_BITS + IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEC,
        S_UPD,
        S_FIN
    } t_state;

    t_state                r_state;
    logic [CFG_W-1:0]      r_cap;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [OCC_W-1:0]      r_occ;
    logic [PTR_W-1:0]      r_ptr;
    logic                  r_rvld;
    logic [IDX_W-1:0]      r_ridx;
    logic [KEY_BITS-1:0]   r_key;

    // decision for the current lookup
    logic                  r_dec_hit;
    logic [IDX_W-1:0]      r_dec_slot;
    logic [COUNT_BITS-1:0] r_dec_count;
    logic [IDX_W-1:0]      r_dec_limit;
    logic                  r_dec_all;
    logic                  r_dec_ev;
    logic [KEY_BITS-1:0]   r_dec_evkey;

    // output register
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [IDX_W-1:0]      r_out_slot;
    logic [COUNT_BITS-1:0] r_out_count;
    logic                  r_out_ev;
    logic [KEY_BITS-1:0]   r_out_evkey;

    // RAM and scan wiring
    logic                  w_issue;
    logic [MEM_W-1:0]      w_rdata;
    logic [KEY_BITS-1:0]   w_rd_key;
    logic [COUNT_BITS-1:0] w_rd_cnt;
    logic [IDX_W-1:0]      w_rd_rank;
    logic                  w_rd_valid;
    logic                  w_we;
    logic [MEM_W-1:0]      w_wdata;
    logic                  w_self;
    logic                  w_age;
    t_scan_ctl             w_scan_ctl;
    t_scan_flags           w_flags;
    logic [IDX_W-1:0]      w_hit_idx, w_vic_idx, w_free_idx, w_hit_rank, w_vic_rank;
    logic [COUNT_BITS-1:0] w_hit_count;
    logic [KEY_BITS-1:0]   w_vic_key;

    // decision logic
    logic [CMP_W-1:0]      w_cap_ext;
    logic [CMP_W-1:0]      w_cap;
    logic                  w_full;
    logic [COUNT_BITS-1:0] w_hit_next;
    logic [IDX_W-1:0]      n_dec_slot;
    logic [COUNT_BITS-1:0] n_dec_count;
    logic [IDX_W-1:0]      n_dec_limit;
    logic                  n_dec_all;
    logic                  n_dec_ev;
    logic [KEY_BITS-1:0]   n_dec_evkey;
    logic                  n_set_valid;
    logic                  w_out_free;

    // read issue during both passes
    assign w_issue = ((r_state == S_SCAN) || (r_state == S_UPD)) &&
                     (r_ptr != PTR_W'(MAX_ENTRIES));

    lfu_dir_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ridx),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // entry word: key | count | rank
    assign w_rd_key   = w_rdata[MEM_W-1 -: KEY_BITS];
    assign w_rd_cnt   = w_rdata[IDX_W +: COUNT_BITS];
    assign w_rd_rank  = w_rdata[IDX_W-1:0];
    assign w_rd_valid = r_valid[r_ridx];

    assign w_scan_ctl.clear = (r_state == S_IDLE);
    assign w_scan_ctl.en    = (r_state == S_SCAN) && r_rvld;

    lfu_dir_scan #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_scan_ctl),
        .i_idx        (r_ridx),
        .i_valid      (w_rd_valid),
        .i_key        (w_rd_key),
        .i_count      (w_rd_cnt),
        .i_rank       (w_rd_rank),
        .i_lookup_key (r_key),
        .o_flags      (w_flags),
        .o_hit_idx    (w_hit_idx),
        .o_hit_count  (w_hit_count),
        .o_hit_rank   (w_hit_rank),
        .o_vic_idx    (w_vic_idx),
        .o_vic_key    (w_vic_key),
        .o_vic_rank   (w_vic_rank),
        .o_free_idx   (w_free_idx)
    );

    // update pass: write the chosen entry, age the others below the limit (every valid one when r_dec_all is set)
    assign w_self  = (r_ridx == r_dec_slot);
    assign w_age   = w_rd_valid && (r_dec_all || (w_rd_rank < r_dec_limit));
    assign w_we    = (r_state == S_UPD) && r_rvld && (w_self || w_age);
    assign w_wdata = w_self ? {r_key, r_dec_count, IDX_W'(0)}
                            : {w_rd_key, w_rd_cnt, w_rd_rank + IDX_W'(1)};

    // effective capacity: zero acts as one, clipped to the table size
    assign w_cap_ext = CMP_W'(r_cap);
    always_comb begin
        priority if (w_cap_ext == CMP_W'(0)) begin
            w_cap = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(MAX_ENTRIES)) begin
            w_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            w_cap = w_cap_ext;
        end
    end
    assign w_full = (CMP_W'(r_occ) >= w_cap);

    // saturating count on a hit
    assign w_hit_next = (w_hit_count == '1) ? w_hit_count : w_hit_count + COUNT_BITS'(1);

    // pick slot, new count, aging limit and any eviction
    always_comb begin
        n_dec_slot  = '0;
        n_dec_count = COUNT_BITS'(1);
        n_dec_limit = '0;
        n_dec_all   = 1'b0;
        n_dec_ev    = 1'b0;
        n_dec_evkey = '0;
        n_set_valid = 1'b0;
        priority if (w_flags.found) begin
            n_dec_slot  = w_hit_idx;
            n_dec_count = w_hit_next;
            n_dec_limit = w_hit_rank;
        end else if (w_full && w_flags.have_victim) begin
            n_dec_slot  = w_vic_idx;
            n_dec_limit = w_vic_rank;
            n_dec_ev    = 1'b1;
            n_dec_evkey = w_vic_key;
        end else begin
            n_dec_slot  = w_flags.have_free ? w_free_idx : IDX_W'(0);
            n_dec_all   = 1'b1;
            n_set_valid = w_flags.have_free;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // sequencer, capacity register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_valid     <= '0;
            r_occ       <= '0;
            r_ptr       <= '0;
            r_rvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_rvld <= w_issue;
            r_ridx <= r_ptr[IDX_W-1:0];
            if (w_issue) begin
                r_ptr <= r_ptr + PTR_W'(1);
            end
            // the output load in S_FIN covers the drain of the old beat
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_key   <= i_lookup_key;
                        r_ptr   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // last read data is taken by the tracker at this edge
                    if (!w_issue) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_dec_hit   <= w_flags.found;
                    r_dec_slot  <= n_dec_slot;
                    r_dec_count <= n_dec_count;
                    r_dec_limit <= n_dec_limit;
                    r_dec_all   <= n_dec_all;
                    r_dec_ev    <= n_dec_ev;
                    r_dec_evkey <= n_dec_evkey;
                    if (n_set_valid) begin
                        r_valid[n_dec_slot] <= 1'b1;
                        r_occ               <= r_occ + OCC_W'(1);
                    end
                    r_ptr   <= '0;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (!w_issue) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_dec_hit;
                        r_out_slot  <= r_dec_slot;
                        r_out_count <= r_dec_count;
                        r_out_ev    <= r_dec_ev;
                        r_out_evkey <= r_dec_evkey;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_slot        = r_out_slot;
    assign o_new_count   = r_out_count;
    assign o_evicted     = r_out_ev;
    assign o_evicted_key = r_out_evkey;

    // occupancy tracks the valid bits
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy count differs from valid bits");

    // occupancy never exceeds the table
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ) <= MAX_ENTRIES)
        else $error("occupancy above table size");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !(r_dec_hit && r_dec_ev))
        else $error("hit flagged together with eviction");

endmodule
